/* hw/rtl/fmtg_pkg.sv */
// ============================================================================
// fmtg_pkg
// Shared types, constants and the sine table builder for the FM tone generator.
// ============================================================================
package fmtg_pkg;

    // Sine table entries are Q0.15 magnitudes
    localparam int unsigned SINE_W     = 15;
    localparam int unsigned SINE_MAX   = 32767;

    // Field and register widths
    localparam int unsigned STEP_W     = 31;
    localparam int unsigned DEPTH_W    = 31;
    localparam int unsigned AMP_W      = 23;
    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned CFG_DATA_W = 31;

    // Product of a sine magnitude with the widest operand
    localparam int unsigned PROD_W     = SINE_W + DEPTH_W;

    // Quarter turn in Q30 radians
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor divisors (2n)(2n+1) for n = 1..6
    localparam longint unsigned TERM_DIV [0:5] = '{64'd6, 64'd20, 64'd42,
                                                    64'd72, 64'd110, 64'd156};

    // Phase store layout
    localparam int unsigned STORE_DEPTH = 2;
    localparam logic        ADDR_MOD    = 1'b0;
    localparam logic        ADDR_CAR    = 1'b1;

    // Configuration register indexes
    localparam logic REG_MOD_DEPTH = 1'b0;
    localparam logic REG_AMPLITUDE = 1'b1;

    // Per-item sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DEV,
        ST_CAR,
        ST_AMP,
        ST_OUT
    } fmtg_state_t;

    // Table entry k of a quarter wave with 2^tbits steps (elaboration only)
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned tbits);
        longint unsigned x;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned s;
        longint unsigned v;
        int unsigned     n;
        x    = (HALF_PI_Q30 * 64'(k)) >> tbits;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TERM_DIV[n-1];
            if (n % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        s = (pos > neg) ? pos - neg : 64'd0;
        v = (s * 64'(SINE_MAX) + (64'd1 << 29)) >> 30;
        if (v > 64'(SINE_MAX) || k == (32'd1 << tbits))
            v = 64'(SINE_MAX);
        return v[SINE_W-1:0];
    endfunction

endpackage

/* hw/rtl/fm_tone_generator_unit.sv */
// ============================================================================
// fm_tone_generator_unit
// Two-operator FM tone generator: one signed sample per input word.
// ============================================================================
// Input channel s_*: each word carries carrier_step and mod_step in tdata and
// the loud flag in tuser. Output channel m_*: one 24-bit signed sample per
// input word. The configuration port writes mod_depth_step (index 0) and
// amplitude (index 1); write it only while no word is in flight.
//
// Each word runs through a six-state sequencer: read the modulator phase,
// advance and write it back, look up its sine, scale by the depth, advance
// the carrier phase, look up its sine, scale by the amplitude. Both phases
// live in a two-entry memory with one read port, and a single 15x31
// multiplier serves both products, so a new word is taken only in ST_IDLE,
// after the last one is done. The sample is registered on leaving ST_OUT.
//
// Reset zeroes both phases (through per-entry valid bits) and restores the
// register defaults. A finished sample waits in the output register while
// the next word is processed; if the receiver still stalls when that word is
// done, the sequencer holds in its last state until the register frees.
// ============================================================================
module fm_tone_generator_unit
    import fmtg_pkg::*;
#(
    parameter int unsigned PHASE_BITS      = 32,
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,  // [30:0] carrier_step, [61:31] mod_step, [63:62] zero
    input  logic                  s_tuser,  // [0] loud
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata   // [23:0] sample
);

    localparam int unsigned TB     = SINE_TABLE_BITS;
    localparam int unsigned WIDE_W = PHASE_BITS + STEP_W;
    localparam logic [TB:0] TBL_N  = {1'b1, {TB{1'b0}}};

    fmtg_state_t state_reg, state_next;

    logic [STEP_W-1:0]     cstep_reg;
    logic [STEP_W-1:0]     mstep_reg;
    logic                  loud_reg;
    logic [DEPTH_W-1:0]    mod_depth_reg;
    logic [AMP_W-1:0]      amp_reg;
    logic [PHASE_BITS-1:0] car_phase_reg;
    logic                  sign_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic                  m_valid_reg;

    logic                  in_accept;
    logic                  out_load;
    logic                  store_we;
    logic                  store_waddr;
    logic                  store_raddr;
    logic [PHASE_BITS-1:0] store_wdata;
    logic [PHASE_BITS-1:0] store_rdata;

    logic [WIDE_W-1:0]     mstep_wide;
    logic [WIDE_W-1:0]     cstep_wide;
    logic [WIDE_W-1:0]     dev_wide;
    logic [PHASE_BITS-1:0] new_mod;
    logic [PHASE_BITS-1:0] dev_p;
    logic [PHASE_BITS-1:0] new_car;

    logic [TB+1:0]         top_bits;
    logic [TB:0]           rom_addr;
    logic [SINE_W-1:0]     rom_data;

    logic [DEPTH_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [AMP_W-1:0]      smp_mag;
    logic [SAMPLE_W-1:0]   smp_val;

    fmtg_phase_store #(
        .WIDTH (PHASE_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (store_wdata),
        .rd_addr (store_raddr),
        .rd_data (store_rdata)
    );

    fmtg_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign in_accept = s_tvalid && s_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_accept) state_next = ST_MOD;
            ST_MOD:  state_next = ST_DEV;
            ST_DEV:  state_next = ST_CAR;
            ST_CAR:  state_next = ST_AMP;
            ST_AMP:  state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready    = 1'b0;
        store_we    = 1'b0;
        store_waddr = ADDR_MOD;
        store_raddr = ADDR_CAR;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                store_raddr = ADDR_MOD;
            end
            ST_MOD:
            begin
                store_we    = 1'b1;
                store_waddr = ADDR_MOD;
            end
            ST_CAR:
            begin
                store_we    = 1'b1;
                store_waddr = ADDR_CAR;
            end
            ST_OUT:   out_load = !m_valid_reg || m_tready;
            default:  ;
        endcase
    end

    // Phase arithmetic, modulo one turn
    assign mstep_wide  = {{PHASE_BITS{1'b0}}, mstep_reg};
    assign cstep_wide  = {{PHASE_BITS{1'b0}}, cstep_reg};
    assign dev_wide    = {{PHASE_BITS{1'b0}}, prod_reg[PROD_W-1:SINE_W]};
    assign dev_p       = sign_reg ? (PHASE_BITS'(0) - dev_wide[PHASE_BITS-1:0])
                                  : dev_wide[PHASE_BITS-1:0];
    assign new_mod     = store_rdata + mstep_wide[PHASE_BITS-1:0];
    assign new_car     = car_phase_reg + cstep_wide[PHASE_BITS-1:0] + dev_p;
    assign store_wdata = (state_reg == ST_MOD) ? new_mod : new_car;

    // Quadrant fold of the phase being written
    assign top_bits = store_wdata[PHASE_BITS-1 -: TB+2];
    assign rom_addr = top_bits[TB] ? (TBL_N - {1'b0, top_bits[TB-1:0]})
                                   : {1'b0, top_bits[TB-1:0]};

    // Shared multiplier: depth in ST_DEV, amplitude in ST_AMP
    assign mul_b = (state_reg == ST_DEV) ? mod_depth_reg : DEPTH_W'(amp_reg);
    assign mul_p = PROD_W'(rom_data) * PROD_W'(mul_b);

    // Sample, rounded toward zero; zero when the loud flag is clear
    assign smp_mag = prod_reg[SINE_W +: AMP_W];
    assign smp_val = !loud_reg ? '0
                   : sign_reg  ? (SAMPLE_W'(0) - {1'b0, smp_mag})
                               : {1'b0, smp_mag};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            mod_depth_reg <= DEPTH_W'(9842633);
            amp_reg       <= AMP_W'(5000000);
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_MOD_DEPTH: mod_depth_reg <= cfg_wdata[DEPTH_W-1:0];
                    REG_AMPLITUDE: amp_reg       <= cfg_wdata[AMP_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cstep_reg <= s_tdata[STEP_W-1:0];
            mstep_reg <= s_tdata[2*STEP_W-1:STEP_W];
            loud_reg  <= s_tuser;
        end
        if (state_reg == ST_MOD || state_reg == ST_CAR)
        begin
            sign_reg <= top_bits[TB+1];
        end
        if (state_reg == ST_DEV)
        begin
            car_phase_reg <= store_rdata;
        end
        if (state_reg == ST_DEV || state_reg == ST_AMP)
        begin
            prod_reg <= mul_p;
        end
        if (out_load)
        begin
            sample_reg <= smp_val;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sample_reg;

endmodule

/* hw/rtl/fmtg_ram.sv */
// ============================================================================
// fmtg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module fmtg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/fmtg_sine_rom.sv */
// ============================================================================
// fmtg_sine_rom
// Quarter-wave Q0.15 sine table, 2^SINE_TABLE_BITS + 1 entries, registered read.
// ============================================================================
module fmtg_sine_rom
    import fmtg_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                       clk,
    input  logic [SINE_TABLE_BITS:0]   addr,
    output logic [SINE_W-1:0]          data
);

    localparam int unsigned ENTRIES = (1 << SINE_TABLE_BITS) + 1;

    logic [SINE_W-1:0] tbl [0:ENTRIES-1];
    logic [SINE_W-1:0] data_reg;

    // Build the table contents at elaboration
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_tbl
        localparam logic [SINE_W-1:0] VAL = sine_entry(k, SINE_TABLE_BITS);
        assign tbl[k] = VAL;
    end

    // Registered lookup
    always_ff @(posedge clk)
    begin
        data_reg <= tbl[addr];
    end

    assign data = data_reg;

endmodule

/* hw/rtl/fmtg_phase_store.sv */
// ============================================================================
// fmtg_phase_store
// Phase memory for modulator and carrier, with per-entry valid bits so that
// an entry not written since reset reads as zero.
// ============================================================================
module fmtg_phase_store
    import fmtg_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic             wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [STORE_DEPTH-1:0] valid_reg;
    logic                   rd_valid_reg;
    logic [WIDTH-1:0]       ram_q;

    fmtg_ram #(
        .WIDTH (WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Track written entries and align the flag with the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Unwritten entries read as zero phase
    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule
